[hw/rtl/lrms_pkg.sv]
// lrms_pkg: shared widths, types and constants for the lattice ray march shader
// used by every module of the block; depends on nothing
`default_nettype none

package lrms_pkg;

   localparam int COORD_BITS     = 16;
   localparam int ORIGIN_BITS    = 16;
   localparam int DIR_BITS       = 17;
   localparam int SHIFT_BITS     = 4;
   localparam int STEP_BITS      = 8;
   localparam int LEVEL_BITS     = 15;
   localparam int TOL_BITS       = 16;
   localparam int KIND_BITS      = 2;
   localparam int BRIGHT_BITS    = 5;
   localparam int COLOR_BITS     = 10;
   localparam int FINE_BITS      = 6;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam int DIR_EXT_BITS    = (COORD_BITS > DIR_BITS) ? COORD_BITS : DIR_BITS;
   localparam int ORIGIN_EXT_BITS = (COORD_BITS > ORIGIN_BITS) ? COORD_BITS : ORIGIN_BITS;
   localparam int CMP_BITS        = (COORD_BITS + 1 > TOL_BITS + 1) ? COORD_BITS + 1
                                                                    : TOL_BITS + 1;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef coord_type [2:0]       coord_vec_type;
   typedef logic [DIR_BITS-1:0]   dir_type;
   typedef dir_type [2:0]         dir_vec_type;

   localparam logic [SHIFT_BITS-1:0]  START_SHIFT = SHIFT_BITS'(7);
   localparam logic [SHIFT_BITS-1:0]  MIN_SHIFT   = SHIFT_BITS'(1);
   localparam logic [FINE_BITS-1:0]   FINE_BASE   = FINE_BITS'(8);
   localparam logic [COLOR_BITS-1:0]  MAX_COLOUR  = COLOR_BITS'(31);

   localparam logic [STEP_BITS-1:0]  STEP_LIMIT_RESET = STEP_BITS'(100);
   localparam logic [LEVEL_BITS-1:0] LEVEL_RESET      = LEVEL_BITS'(16'h3000);
   localparam logic [TOL_BITS-1:0]   TOL_RESET        = TOL_BITS'(16'h8C00);

   typedef enum logic [KIND_BITS-1:0] {
      KIND_NONE    = 2'd0,
      KIND_OCTA    = 2'd1,
      KIND_BAR     = 2'd2,
      KIND_BAR_ODD = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_STEP_LIMIT     = 2'd0,
      CSR_SURFACE_LEVEL  = 2'd1,
      CSR_TOLERANCE_BASE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADVANCE,
      ST_EVAL
   } state_type;

endpackage

`default_nettype wire

[hw/rtl/lrms_advance_unit.sv]
// lrms_advance_unit: moves the ray position by one shifted direction step
// depends on lrms_pkg
`default_nettype none

module lrms_advance_unit import lrms_pkg::*; (
   input  wire coord_vec_type         coord,
   input  wire dir_vec_type           dir,
   input  wire logic [SHIFT_BITS-1:0] shift,
   input  wire logic                  negate,
   output      coord_vec_type         coord_next
);

   for (genvar i = 0; i < 3; i++) begin : g_axis
      logic signed [DIR_BITS-1:0]     shifted;
      logic signed [DIR_EXT_BITS-1:0] extended;
      coord_type                      delta;

      // arithmetic shift is a floor shift
      assign shifted  = $signed(dir[i]) >>> shift;
      assign extended = DIR_EXT_BITS'(shifted);
      assign delta    = extended[COORD_BITS-1:0];

      always_comb begin
         if (negate) begin
            coord_next[i] = coord[i] - delta;
         end else begin
            coord_next[i] = coord[i] + delta;
         end
      end
   end

endmodule

`default_nettype wire

[hw/rtl/lrms_surface_unit.sv]
// lrms_surface_unit: distance test of one ray position against the lattice surfaces
// depends on lrms_pkg
`default_nettype none

module lrms_surface_unit import lrms_pkg::*; (
   input  wire coord_vec_type         coord,
   input  wire logic [SHIFT_BITS-1:0] shift,
   input  wire logic [LEVEL_BITS-1:0] surface_level,
   input  wire logic [TOL_BITS-1:0]   tolerance_base,
   output      kind_type              kind
);

   coord_type             mag [3];
   logic [COORD_BITS:0]   diff [3];
   coord_type             adiff [3];
   logic [CMP_BITS-1:0]   oct_sum;
   logic [CMP_BITS-1:0]   bar_sum;
   logic [TOL_BITS-1:0]   tol;
   logic [CMP_BITS-1:0]   oct_lim;
   logic [CMP_BITS-1:0]   bar_lim;
   logic                  oct_hit;
   logic                  bar_hit;
   logic                  odd_cell;

   for (genvar i = 0; i < 3; i++) begin : g_mag
      assign mag[i] = coord[i][COORD_BITS-1] ? (~coord[i] + 1'b1) : coord[i];
   end

   // pairs x-z, y-x, z-y
   assign diff[0] = {1'b0, mag[0]} - {1'b0, mag[2]};
   assign diff[1] = {1'b0, mag[1]} - {1'b0, mag[0]};
   assign diff[2] = {1'b0, mag[2]} - {1'b0, mag[1]};

   for (genvar i = 0; i < 3; i++) begin : g_adiff
      logic [COORD_BITS:0] neg;
      assign neg      = ~diff[i] + 1'b1;
      assign adiff[i] = diff[i][COORD_BITS] ? neg[COORD_BITS-1:0] : diff[i][COORD_BITS-1:0];
   end

   assign oct_sum = CMP_BITS'(mag[0]) + CMP_BITS'(mag[1]) + CMP_BITS'(mag[2]);
   assign bar_sum = CMP_BITS'(adiff[0]) + CMP_BITS'(adiff[1]) + CMP_BITS'(adiff[2]);

   assign tol     = tolerance_base >> shift;
   assign oct_lim = CMP_BITS'(tol) + (CMP_BITS'(surface_level) << 1);
   assign bar_lim = CMP_BITS'(tol) + CMP_BITS'(surface_level);

   assign oct_hit  = oct_sum < oct_lim;
   assign bar_hit  = bar_sum < bar_lim;
   assign odd_cell = coord[0][COORD_BITS-1] ^ coord[1][COORD_BITS-1] ^ coord[2][COORD_BITS-1];

   always_comb begin
      priority if (bar_hit) begin
         kind = odd_cell ? KIND_BAR_ODD : KIND_BAR;
      end else if (oct_hit) begin
         kind = KIND_OCTA;
      end else begin
         kind = KIND_NONE;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/lattice_ray_march_shader.sv]
// lattice_ray_march_shader: adaptive ray marcher through a lattice of octahedra and bars
// each march pass is an advance, then a surface test; the step limit is checked before each
// advance and ends a march with no surface hit; the result strobe follows in the next cycle
// requests: a new request is taken only while idle, so one march ends before the next starts;
// a new request is taken in the cycle of the result strobe
// reset: config registers to defaults, sequencer idle, no result strobe
`default_nettype none

module lattice_ray_march_shader import lrms_pkg::*; (
   input  wire  logic                          clock,
   input  wire  logic                          reset,
   input  wire  logic                          start,
   output       logic                          busy,
   input  wire  logic signed [ORIGIN_BITS-1:0] req_origin_x,
   input  wire  logic signed [ORIGIN_BITS-1:0] req_origin_y,
   input  wire  logic signed [ORIGIN_BITS-1:0] req_origin_z,
   input  wire  logic signed [DIR_BITS-1:0]    req_dir_x,
   input  wire  logic signed [DIR_BITS-1:0]    req_dir_y,
   input  wire  logic signed [DIR_BITS-1:0]    req_dir_z,
   input  wire  logic                          csr_wr_en,
   input  wire  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire  logic [CSR_DATA_BITS-1:0]      csr_wdata,
   output       logic                          rsp_valid,
   output       logic [KIND_BITS-1:0]          rsp_surface_kind,
   output       logic [BRIGHT_BITS-1:0]        rsp_brightness
);

   state_type                state_ff, state_in;
   coord_vec_type            coord_ff, coord_in;
   dir_vec_type              dir_ff, dir_in;
   logic [SHIFT_BITS-1:0]    shift_ff, shift_in;
   logic [STEP_BITS-1:0]     steps_ff, steps_in;
   logic                     hit_prev_ff, hit_prev_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   kind_type                 rsp_kind_ff, rsp_kind_in;
   logic [BRIGHT_BITS-1:0]   rsp_bright_ff, rsp_bright_in;
   logic [STEP_BITS-1:0]     step_limit_ff;
   logic [LEVEL_BITS-1:0]    surface_level_ff;
   logic [TOL_BITS-1:0]      tolerance_base_ff;

   logic signed [ORIGIN_EXT_BITS-1:0] ox_ext, oy_ext, oz_ext;
   coord_vec_type            coord_adv;
   kind_type                 kind;
   logic                     hit;
   logic                     limit_reached;
   logic [SHIFT_BITS-1:0]    shift_inc;
   logic                     fine_enough;
   logic [COLOR_BITS-1:0]    color;
   logic [BRIGHT_BITS-1:0]   bright_clamped;

   logic                     do_load;
   logic                     do_give_up;
   logic                     do_advance;
   logic                     do_finish;
   logic                     do_refine;
   logic                     do_miss;

   lrms_advance_unit u_advance (
      .coord      (coord_ff),
      .dir        (dir_ff),
      .shift      (shift_ff),
      .negate     (hit_prev_ff),
      .coord_next (coord_adv)
   );

   lrms_surface_unit u_surface (
      .coord          (coord_ff),
      .shift          (shift_ff),
      .surface_level  (surface_level_ff),
      .tolerance_base (tolerance_base_ff),
      .kind           (kind)
   );

   assign hit           = kind != KIND_NONE;
   assign limit_reached = steps_ff >= step_limit_ff;
   assign shift_inc     = shift_ff + 1'b1;
   assign fine_enough   = (FINE_BITS'(shift_inc) + FINE_BITS'(steps_ff[STEP_BITS-1:3]))
                          >= FINE_BASE;

   // colour level 31 - steps + shift + 1, negative when the top bit is set
   assign color = MAX_COLOUR + COLOR_BITS'(shift_inc) - COLOR_BITS'(steps_ff);

   always_comb begin
      priority if (color[COLOR_BITS-1]) begin
         bright_clamped = '0;
      end else if (color > MAX_COLOUR) begin
         bright_clamped = BRIGHT_BITS'(MAX_COLOUR);
      end else begin
         bright_clamped = color[BRIGHT_BITS-1:0];
      end
   end

   assign ox_ext = ORIGIN_EXT_BITS'(req_origin_x);
   assign oy_ext = ORIGIN_EXT_BITS'(req_origin_y);
   assign oz_ext = ORIGIN_EXT_BITS'(req_origin_z);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            state_in = limit_reached ? ST_IDLE : ST_EVAL;
         end
         ST_EVAL: begin
            state_in = (hit && fine_enough) ? ST_IDLE : ST_ADVANCE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      do_load    = 1'b0;
      do_give_up = 1'b0;
      do_advance = 1'b0;
      do_finish  = 1'b0;
      do_refine  = 1'b0;
      do_miss    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            do_load = start;
         end
         ST_ADVANCE: begin
            do_give_up = limit_reached;
            do_advance = !limit_reached;
         end
         ST_EVAL: begin
            do_finish = hit && fine_enough;
            do_refine = hit && !fine_enough;
            do_miss   = !hit;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      coord_in      = coord_ff;
      dir_in        = dir_ff;
      shift_in      = shift_ff;
      steps_in      = steps_ff;
      hit_prev_in   = hit_prev_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_bright_in = rsp_bright_ff;

      if (do_load) begin
         coord_in[0] = ox_ext[COORD_BITS-1:0];
         coord_in[1] = oy_ext[COORD_BITS-1:0];
         coord_in[2] = oz_ext[COORD_BITS-1:0];
         dir_in[0]   = req_dir_x;
         dir_in[1]   = req_dir_y;
         dir_in[2]   = req_dir_z;
         shift_in    = START_SHIFT;
         steps_in    = '0;
         hit_prev_in = 1'b0;
      end
      if (do_advance) begin
         coord_in = coord_adv;
      end
      if (do_give_up) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_NONE;
         rsp_bright_in = '0;
      end
      if (do_finish) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = kind;
         rsp_bright_in = bright_clamped;
      end
      if (do_refine) begin
         shift_in    = shift_inc;
         hit_prev_in = 1'b1;
      end
      if (do_miss) begin
         if (!hit_prev_ff && (shift_ff > MIN_SHIFT)) begin
            shift_in = shift_ff - 1'b1;
         end
         steps_in    = steps_ff + 1'b1;
         hit_prev_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         step_limit_ff     <= STEP_LIMIT_RESET;
         surface_level_ff  <= LEVEL_RESET;
         tolerance_base_ff <= TOL_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_STEP_LIMIT: begin
                  step_limit_ff <= csr_wdata[STEP_BITS-1:0];
               end
               CSR_SURFACE_LEVEL: begin
                  surface_level_ff <= csr_wdata[LEVEL_BITS-1:0];
               end
               CSR_TOLERANCE_BASE: begin
                  tolerance_base_ff <= csr_wdata[TOL_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      coord_ff      <= coord_in;
      dir_ff        <= dir_in;
      shift_ff      <= shift_in;
      steps_ff      <= steps_in;
      hit_prev_ff   <= hit_prev_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_bright_ff <= rsp_bright_in;
   end

   assign busy             = state_ff != ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_surface_kind = rsp_kind_ff;
   assign rsp_brightness   = rsp_bright_ff;

endmodule

`default_nettype wire

[hw/rtl/lrms_checker.sv]
// lrms_checker: port-level checks of the ray march shader over time
// depends on lrms_pkg; bound to lattice_ray_march_shader
`default_nettype none

module lrms_checker import lrms_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire logic                   rsp_valid,
   input wire logic [KIND_BITS-1:0]   rsp_surface_kind,
   input wire logic [BRIGHT_BITS-1:0] rsp_brightness
);

   // an accepted request makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // a result only ends a busy stretch
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result strobe without a preceding busy stretch");

   // leaving busy always delivers a result
   a_busy_end_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("busy ended without a result");

   // a miss is reported dark
   a_miss_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_surface_kind == KIND_NONE)) |-> (rsp_brightness == '0))
      else $error("no surface but nonzero brightness");

endmodule

bind lattice_ray_march_shader lrms_checker u_lrms_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_surface_kind (rsp_surface_kind),
   .rsp_brightness   (rsp_brightness)
);

`default_nettype wire
